FILE: design/mse_pkg.sv
// Package for the MIPS subset executor: shared widths, opcode and funct codes,
// status codes and the memory base address. No dependencies.
package mse_pkg;

    localparam int XLEN     = 32;
    localparam int REG_AW   = 5;
    localparam int RF_DEPTH = 32;
    localparam int ST_W     = 3;

    localparam logic [XLEN-1:0]   MEM_BASE = 32'h0040_0000;
    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_RA   = 5'd31;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_SRA  = 6'd3;
    localparam logic [5:0] FN_SLLV = 6'd4;
    localparam logic [5:0] FN_SRLV = 6'd6;
    localparam logic [5:0] FN_SRAV = 6'd7;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_SLT  = 6'd42;
    localparam logic [5:0] FN_SLTU = 6'd43;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_HALT        = 3'd1,
        ST_BAD_ADDR    = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_STOPPED     = 3'd4
    } t_status;

endpackage

FILE: design/mse_instr_if.sv
// Instruction channel: valid/ready handshake carrying one instruction word per beat.
// Depends on mse_pkg.
interface mse_instr_if;
    import mse_pkg::*;

    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink (input valid, input instr_word, output ready);
endinterface

interface mse_result_if;
    import mse_pkg::*;

    logic              valid;
    logic              ready;
    logic [XLEN-1:0]   next_pc;
    logic              reg_written;
    logic [REG_AW-1:0] reg_index;
    logic              mem_written;
    logic [XLEN-1:0]   mem_address;
    logic [ST_W-1:0]   status;

    modport source (
        output valid, output next_pc, output reg_written, output reg_index,
        output mem_written, output mem_address, output status, input ready
    );
    modport sink (
        input valid, input next_pc, input reg_written, input reg_index,
        input mem_written, input mem_address, input status, output ready
    );
endinterface

FILE: design/mips_subset_instruction_executor.sv
// MIPS integer-subset executor: pc register; register file and word memory in synchronous RAMs.
// Depends on mse_pkg and the channel interfaces in mse_instr_if.sv.
//
// i_instr takes one instruction word per beat; o_result gives one beat per
// instruction with the new pc, register and store reports and a status code.
// Three stages: accept and register-file read, execute with memory access,
// write back into the output register. An instruction can be accepted every
// cycle while o_result is not stalled and no clearing pass runs. Dependent
// instructions are forwarded from the writeback stage, including a load's data
// straight off the memory read port, so there is no interlock.
// After reset a clearing pass writes zero to every memory word and register
// while i_instr.ready stays low.
// When o_result is stalled the output register holds its beat; the two
// inner stages still fill, then i_instr.ready drops until the output drains.
// Once a zero word or a bad load/store address stops the block, every later
// beat reports the stopped status and changes nothing.
module mips_subset_instruction_executor #(
    parameter int INSTR_WORDS = 1024,
    parameter int DATA_WORDS  = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mse_instr_if.sink     i_instr,
    mse_result_if.source  o_result
);
    import mse_pkg::*;

    localparam int MEM_WORDS = INSTR_WORDS + DATA_WORDS;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CLR_LEN   = (MEM_WORDS > RF_DEPTH) ? MEM_WORDS : RF_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN) + 1;
    localparam logic [29:0]      MEM_WORDS_W = 30'(MEM_WORDS);
    localparam logic [CLR_W-1:0] CLR_LAST    = CLR_W'(CLR_LEN - 1);
    localparam logic [CLR_W-1:0] CLR_RF_END  = CLR_W'(RF_DEPTH);
    localparam logic [CLR_W-1:0] CLR_MEM_END = CLR_W'(MEM_WORDS);

    logic [XLEN-1:0] r_rf [RF_DEPTH];
    logic [XLEN-1:0] r_word_mem [MEM_WORDS];

    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [XLEN-1:0]  r_pc;
    logic             r_stopped;

    logic             r_b_valid;
    logic [XLEN-1:0]  r_b_instr;
    logic [XLEN-1:0]  r_rf_a;
    logic [XLEN-1:0]  r_rf_b;

    logic              r_c_valid;
    logic              r_c_wb;
    logic              r_c_load;
    logic [REG_AW-1:0] r_c_rd;
    logic [XLEN-1:0]   r_c_val;
    logic [XLEN-1:0]   r_c_npc;
    logic              r_c_mw;
    logic [XLEN-1:0]   r_c_ma;
    t_status           r_c_st;
    logic [XLEN-1:0]   r_mem_rd;

    logic              r_out_valid;
    logic [XLEN-1:0]   r_out_next_pc;
    logic              r_out_reg_written;
    logic [REG_AW-1:0] r_out_reg_index;
    logic              r_out_mem_written;
    logic [XLEN-1:0]   r_out_mem_address;
    t_status           r_out_status;

    logic adv_out, c_free, adv_b, b_free, acc;

    assign adv_out       = r_c_valid && (!r_out_valid || o_result.ready);
    assign c_free        = !r_c_valid || adv_out;
    assign adv_b         = r_b_valid && c_free;
    assign b_free        = !r_b_valid || adv_b;
    assign i_instr.ready = b_free && !r_clr_busy;
    assign acc           = i_instr.valid && i_instr.ready;

    // clearing pass
    logic clr_rf_we, clr_mem_we;

    assign clr_rf_we  = r_clr_busy && (r_clr_cnt < CLR_RF_END);
    assign clr_mem_we = r_clr_busy && (r_clr_cnt < CLR_MEM_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // register file
    logic [XLEN-1:0]   c_wdata;
    logic              rf_we;
    logic [REG_AW-1:0] rf_wa;
    logic [XLEN-1:0]   rf_wd;
    logic [REG_AW-1:0] rs_sel, rt_sel;
    logic [REG_AW-1:0] b_rs, b_rt;

    assign b_rs    = r_b_instr[25:21];
    assign b_rt    = r_b_instr[20:16];
    assign c_wdata = r_c_load ? r_mem_rd : r_c_val;
    assign rf_we   = clr_rf_we || (adv_out && r_c_wb);
    assign rf_wa   = r_clr_busy ? r_clr_cnt[REG_AW-1:0] : r_c_rd;
    assign rf_wd   = r_clr_busy ? '0 : c_wdata;
    assign rs_sel  = acc ? i_instr.instr_word[25:21] : b_rs;
    assign rt_sel  = acc ? i_instr.instr_word[20:16] : b_rt;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (rf_we && rf_wa == rs_sel) begin
            r_rf_a <= rf_wd;
        end else if (acc) begin
            r_rf_a <= r_rf[rs_sel];
        end
        if (rf_we && rf_wa == rt_sel) begin
            r_rf_b <= rf_wd;
        end else if (acc) begin
            r_rf_b <= r_rf[rt_sel];
        end
    end

    // execute stage
    logic [XLEN-1:0] op_a, op_b;
    logic [5:0]      b_op, b_fn;
    logic [4:0]      b_sa;
    logic [REG_AW-1:0] b_rd;
    logic [15:0]     b_zimm;
    logic [XLEN-1:0] b_simm, b_zext, pc4, br_tgt, j_tgt, addr, addr_off;
    logic            addr_ok;
    logic [MEM_AW-1:0] b_widx;

    assign op_a = (r_c_valid && r_c_wb && r_c_rd == b_rs) ? c_wdata : r_rf_a;
    assign op_b = (r_c_valid && r_c_wb && r_c_rd == b_rt) ? c_wdata : r_rf_b;

    assign b_op     = r_b_instr[31:26];
    assign b_fn     = r_b_instr[5:0];
    assign b_sa     = r_b_instr[10:6];
    assign b_rd     = r_b_instr[15:11];
    assign b_zimm   = r_b_instr[15:0];
    assign b_zext   = {16'h0000, b_zimm};
    assign b_simm   = {{16{b_zimm[15]}}, b_zimm};
    assign pc4      = r_pc + 32'd4;
    assign br_tgt   = pc4 + {b_simm[29:0], 2'b00};
    assign j_tgt    = {pc4[31:28], r_b_instr[25:0], 2'b00};
    assign addr     = op_a + b_simm;
    assign addr_off = addr - MEM_BASE;
    assign addr_ok  = (addr[1:0] == 2'b00) && (addr >= MEM_BASE)
                      && (addr_off[31:2] < MEM_WORDS_W);
    assign b_widx   = addr_off[MEM_AW+1:2];

    t_status           n_st;
    logic              wb, is_load, is_store;
    logic [REG_AW-1:0] dest;
    logic [XLEN-1:0]   val, npc;

    always_comb begin
        n_st     = ST_OK;
        wb       = 1'b0;
        is_load  = 1'b0;
        is_store = 1'b0;
        dest     = b_rd;
        val      = '0;
        npc      = pc4;
        if (r_stopped) begin
            n_st = ST_STOPPED;
        end else if (r_b_instr == '0) begin
            n_st = ST_HALT;
        end else if (b_op == OP_SPECIAL) begin
            wb = 1'b1;
            case (b_fn)
                FN_ADD, FN_ADDU: val = op_a + op_b;
                FN_SUB, FN_SUBU: val = op_a - op_b;
                FN_AND:  val = op_a & op_b;
                FN_OR:   val = op_a | op_b;
                FN_XOR:  val = op_a ^ op_b;
                FN_NOR:  val = ~(op_a | op_b);
                FN_SLT:  val = {31'd0, $signed(op_a) < $signed(op_b)};
                FN_SLTU: val = {31'd0, op_a < op_b};
                FN_SLL:  val = op_b << b_sa;
                FN_SRL:  val = op_b >> b_sa;
                FN_SRA:  val = $unsigned($signed(op_b) >>> b_sa);
                FN_SLLV: val = op_b << op_a[4:0];
                FN_SRLV: val = op_b >> op_a[4:0];
                FN_SRAV: val = $unsigned($signed(op_b) >>> op_a[4:0]);
                FN_JR: begin
                    wb  = 1'b0;
                    npc = op_a;
                end
                default: begin
                    wb   = 1'b0;
                    n_st = ST_UNSUPPORTED;
                end
            endcase
        end else begin
            wb   = 1'b1;
            dest = b_rt;
            case (b_op)
                OP_ADDI, OP_ADDIU: val = op_a + b_simm;
                OP_ANDI:  val = op_a & b_zext;
                OP_ORI:   val = op_a | b_zext;
                OP_XORI:  val = op_a ^ b_zext;
                OP_LUI:   val = {b_zimm, 16'h0000};
                OP_SLTI:  val = {31'd0, $signed(op_a) < $signed(b_simm)};
                OP_SLTIU: val = {31'd0, op_a < b_simm};
                OP_LW: begin
                    is_load = 1'b1;
                    if (!addr_ok) begin
                        n_st = ST_BAD_ADDR;
                    end
                end
                OP_SW: begin
                    wb       = 1'b0;
                    is_store = 1'b1;
                    if (!addr_ok) begin
                        n_st = ST_BAD_ADDR;
                    end
                end
                OP_BEQ: begin
                    wb = 1'b0;
                    if (op_a == op_b) begin
                        npc = br_tgt;
                    end
                end
                OP_BNE: begin
                    wb = 1'b0;
                    if (op_a != op_b) begin
                        npc = br_tgt;
                    end
                end
                OP_J: begin
                    wb  = 1'b0;
                    npc = j_tgt;
                end
                OP_JAL: begin
                    dest = REG_RA;
                    val  = pc4;
                    npc  = j_tgt;
                end
                default: begin
                    wb   = 1'b0;
                    n_st = ST_UNSUPPORTED;
                end
            endcase
        end
    end

    logic            b_ok, n_c_wb, n_c_mw, mem_re, mem_we;
    logic [XLEN-1:0] n_c_npc;

    assign b_ok    = (n_st == ST_OK);
    assign n_c_wb  = b_ok && wb && (dest != REG_ZERO);
    assign n_c_mw  = b_ok && is_store;
    assign n_c_npc = b_ok ? npc : r_pc;
    assign mem_re  = adv_b && b_ok && is_load;
    assign mem_we  = clr_mem_we || (adv_b && n_c_mw);

    // word memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_word_mem[r_clr_busy ? r_clr_cnt[MEM_AW-1:0] : b_widx] <=
                r_clr_busy ? '0 : op_b;
        end
        if (mem_re) begin
            r_mem_rd <= r_word_mem[b_widx];
        end
    end

    // control state and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= MEM_BASE;
            r_stopped   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_b_valid <= 1'b1;
            end else if (adv_b) begin
                r_b_valid <= 1'b0;
            end
            if (adv_b) begin
                r_c_valid <= 1'b1;
            end else if (adv_out) begin
                r_c_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv_b) begin
                r_pc <= n_c_npc;
                if (n_st == ST_HALT || n_st == ST_BAD_ADDR) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_instr <= i_instr.instr_word;
        end
        if (adv_b) begin
            r_c_wb   <= n_c_wb;
            r_c_load <= is_load;
            r_c_rd   <= n_c_wb ? dest : REG_ZERO;
            r_c_val  <= val;
            r_c_npc  <= n_c_npc;
            r_c_mw   <= n_c_mw;
            r_c_ma   <= n_c_mw ? addr : '0;
            r_c_st   <= n_st;
        end
        if (adv_out) begin
            r_out_next_pc     <= r_c_npc;
            r_out_reg_written <= r_c_wb;
            r_out_reg_index   <= r_c_rd;
            r_out_mem_written <= r_c_mw;
            r_out_mem_address <= r_c_ma;
            r_out_status      <= r_c_st;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.next_pc     = r_out_next_pc;
    assign o_result.reg_written = r_out_reg_written;
    assign o_result.reg_index   = r_out_reg_index;
    assign o_result.mem_written = r_out_mem_written;
    assign o_result.mem_address = r_out_mem_address;
    assign o_result.status      = r_out_status;

endmodule
